// ===== rtl/mts_pkg.sv =====
// Shared types and codes for the minimum-tracking stack.
package mts_pkg;

  typedef logic [1:0] func_t;
  typedef logic [1:0] status_t;

  localparam func_t FUNC_PUSH  = 2'd0;
  localparam func_t FUNC_POP   = 2'd1;
  localparam func_t FUNC_QUERY = 2'd2;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  localparam int FieldWidth = 32;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_FILL = 2'b10
  } state_t;

endpackage

// ===== rtl/mts_if.sv =====
// Valid/ready channel interfaces for the operation and result transfers.
interface mts_in_if;
  logic                                 valid;
  logic                                 ready;
  mts_pkg::func_t                       func;
  logic signed [mts_pkg::FieldWidth-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface mts_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mts_pkg::FieldWidth-1:0] result_value;
  mts_pkg::status_t                     status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== rtl/mts_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/min_tracking_stack_top.sv =====
// Minimum-tracking stack: control, cached tops, two stack RAMs and output register.
//
// A stack of signed DATA_WIDTH-bit words that also reports its current minimum.
// The values and the running minima live in two RAMs; the top of each stack is
// cached in a register so push, query and an unused code need no reload state.
// A pop enters a reload state, in which the new tops come back from the RAMs'
// registered read port and in_ch.ready stays low. The result of an operation
// appears in the output register in the cycle after its transfer, and a new
// operation is taken only in a cycle in which no result waits or the waiting
// result transfers. No clearing pass is needed
// after reset. Pop on an empty stack returns status empty with the most negative
// value, a query on an empty stack returns status empty with the most positive
// value, and a push on a full stack is dropped with status full.
module min_tracking_stack_top #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  mts_in_if.sink   in_ch,
  mts_out_if.source out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = mts_pkg::FieldWidth;

  localparam logic [DATA_WIDTH-1:0] WordMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] WordMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  mts_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   vcnt_r, vcnt_nxt;
  logic [CW-1:0]   mcnt_r, mcnt_nxt;
  logic [DATA_WIDTH-1:0] val_top_r, val_top_nxt;
  logic [DATA_WIDTH-1:0] min_top_r, min_top_nxt;
  logic            fill_val_r, fill_val_nxt;
  logic            fill_min_r, fill_min_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [FW-1:0]   out_value_r, out_value_nxt;
  mts_pkg::status_t out_status_r, out_status_nxt;

  logic            in_fire;
  logic [DATA_WIDTH-1:0] x;
  logic signed [DATA_WIDTH-1:0] res;
  logic signed [63:0] res_wide;
  mts_pkg::status_t status;

  logic            v_we, m_we, v_re, m_re;
  logic [AW-1:0]   v_waddr, m_waddr, v_raddr, m_raddr;
  logic [DATA_WIDTH-1:0] v_rdata, m_rdata;

  logic            v_full, v_empty, m_empty, m_full;
  logic            min_push, min_pop;

  assign in_ch.ready = (state_r == mts_pkg::ST_RUN) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Only the low DATA_WIDTH bits of the field are taken, as raw bits.
  assign x = DATA_WIDTH'($unsigned(in_ch.push_value));

  assign v_full  = (vcnt_r == CW'(DEPTH));
  assign v_empty = (vcnt_r == '0);
  assign m_full  = (mcnt_r == CW'(DEPTH));
  assign m_empty = (mcnt_r == '0);

  assign min_push = m_empty || (!m_full && ($signed(x) <= $signed(min_top_r)));
  assign min_pop  = !m_empty && (min_top_r == val_top_r);

  always_comb begin
    state_nxt    = state_r;
    vcnt_nxt     = vcnt_r;
    mcnt_nxt     = mcnt_r;
    val_top_nxt  = val_top_r;
    min_top_nxt  = min_top_r;
    fill_val_nxt = fill_val_r;
    fill_min_nxt = fill_min_r;
    v_we    = 1'b0;
    m_we    = 1'b0;
    v_re    = 1'b0;
    m_re    = 1'b0;
    v_waddr = vcnt_r[AW-1:0];
    m_waddr = mcnt_r[AW-1:0];
    v_raddr = AW'(vcnt_r - CW'(2));
    m_raddr = AW'(mcnt_r - CW'(2));
    res     = '0;
    status  = mts_pkg::STATUS_OK;

    case (state_r)
      mts_pkg::ST_RUN: begin
        if (in_fire) begin
          case (in_ch.func)
            mts_pkg::FUNC_PUSH: begin
              if (v_full) begin
                status = mts_pkg::STATUS_FULL;
              end else begin
                v_we        = 1'b1;
                vcnt_nxt    = vcnt_r + CW'(1);
                val_top_nxt = x;
                if (min_push) begin
                  m_we        = 1'b1;
                  mcnt_nxt    = mcnt_r + CW'(1);
                  min_top_nxt = x;
                end
              end
            end
            mts_pkg::FUNC_POP: begin
              if (v_empty) begin
                status = mts_pkg::STATUS_EMPTY;
                res    = WordMin;
              end else begin
                res      = val_top_r;
                vcnt_nxt = vcnt_r - CW'(1);
                // The entry below the old top becomes the new cached top.
                v_re         = (vcnt_r > CW'(1));
                fill_val_nxt = (vcnt_r > CW'(1));
                fill_min_nxt = 1'b0;
                if (min_pop) begin
                  mcnt_nxt     = mcnt_r - CW'(1);
                  m_re         = (mcnt_r > CW'(1));
                  fill_min_nxt = (mcnt_r > CW'(1));
                end
                state_nxt = mts_pkg::ST_FILL;
              end
            end
            mts_pkg::FUNC_QUERY: begin
              if (m_empty) begin
                status = mts_pkg::STATUS_EMPTY;
                res    = WordMax;
              end else begin
                res = min_top_r;
              end
            end
            default: begin
              status = mts_pkg::STATUS_OK;
            end
          endcase
        end
      end
      mts_pkg::ST_FILL: begin
        if (fill_val_r) begin
          val_top_nxt = v_rdata;
        end
        if (fill_min_r) begin
          min_top_nxt = m_rdata;
        end
        state_nxt = mts_pkg::ST_RUN;
      end
      default: begin
        state_nxt = mts_pkg::ST_RUN;
      end
    endcase
  end

  assign res_wide = 64'(res);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = res_wide[FW-1:0];
      out_status_nxt = status;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mts_pkg::ST_RUN;
      vcnt_r      <= '0;
      mcnt_r      <= '0;
      fill_val_r  <= 1'b0;
      fill_min_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      mcnt_r      <= mcnt_nxt;
      fill_val_r  <= fill_val_nxt;
      fill_min_r  <= fill_min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_top_r    <= val_top_nxt;
    min_top_r    <= min_top_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.status       = out_status_r;

  mts_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (x),
    .re    (v_re),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  mts_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_minimum_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (x),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // The minima stack never holds more entries than the main stack.
  a_min_le_val: assert property (@(posedge clk) disable iff (!rst_n)
    mcnt_r <= vcnt_r)
    else $error("minima count exceeds value count");

  // No operation is taken while the cached tops are being reloaded.
  a_fill_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mts_pkg::ST_FILL) |-> !in_ch.ready)
    else $error("operation taken during top reload");

  // A push that fits grows the main stack by exactly one entry.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.func == mts_pkg::FUNC_PUSH) && !v_full)
      |=> (vcnt_r == $past(vcnt_r) + CW'(1)))
    else $error("push did not grow the stack");

  // Every transfer leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("result missing after transfer");

endmodule
